@@ hdl/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

  localparam int PRIO_W = 8;
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_POP    = 2'd2
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t         cmd;
    logic [PRIO_W-1:0] new_prio;
  } cell_ctl_t;

  typedef struct packed {
    logic                     opcode;
    logic [PRIO_W-1:0]        priority_req;
    logic signed [DATA_W-1:0] payload;
  } in_word_t;

  typedef struct packed {
    status_t                  status;
    logic [PRIO_W-1:0]        out_priority;
    logic signed [DATA_W-1:0] out_payload;
    logic [OCC_W-1:0]         occupancy;
  } out_word_t;

endpackage

@@ hdl/spq_cell.sv @@
`timescale 1ns / 1ps

module spq_cell #(
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  spq_pkg::cell_ctl_t         ctl,
  input  logic [PAYLOAD_WIDTH-1:0]   new_payload,
  input  logic                       left_valid,
  input  logic                       left_gt,
  input  logic [spq_pkg::PRIO_W-1:0] left_prio,
  input  logic [PAYLOAD_WIDTH-1:0]   left_payload,
  input  logic                       right_valid,
  input  logic [spq_pkg::PRIO_W-1:0] right_prio,
  input  logic [PAYLOAD_WIDTH-1:0]   right_payload,
  output logic                       valid,
  output logic                       gt,
  output logic [spq_pkg::PRIO_W-1:0] prio,
  output logic [PAYLOAD_WIDTH-1:0]   payload
);
  import spq_pkg::*;

  logic                     valid_r, valid_nxt;
  logic [PRIO_W-1:0]        prio_r, prio_nxt;
  logic [PAYLOAD_WIDTH-1:0] payload_r, payload_nxt;

  // A stored entry stays ahead of a new one only if its priority is strictly larger.
  assign gt = valid_r && (prio_r > ctl.new_prio);

  always_comb begin
    valid_nxt   = valid_r;
    prio_nxt    = prio_r;
    payload_nxt = payload_r;
    case (ctl.cmd)
      CMD_INSERT: begin
        valid_nxt = valid_r | left_valid;
        if (!gt && left_gt) begin
          prio_nxt    = ctl.new_prio;
          payload_nxt = new_payload;
        end else if (!gt) begin
          prio_nxt    = left_prio;
          payload_nxt = left_payload;
        end
      end
      CMD_POP: begin
        valid_nxt   = right_valid;
        prio_nxt    = right_prio;
        payload_nxt = right_payload;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r    <= prio_nxt;
    payload_r <= payload_nxt;
  end

  assign valid   = valid_r;
  assign prio    = prio_r;
  assign payload = payload_r;

endmodule

@@ hdl/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// A result word is registered at the clock edge that accepts its input word.
// Throughput: one word per cycle unless out_ready stalls; every cell compares against
// the broadcast priority at once and moves by one slot, so no item waits on another.
// Reset (synchronous, active low) empties the queue and drops any pending result.
// Stored priorities and payloads are not cleared; only the valid bits are.

module sorted_priority_queue #(
  parameter int CAPACITY      = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output spq_pkg::out_word_t out_word
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // The cells form a row with the head (highest priority) at index zero.
  // The valid cells are always a contiguous run starting at the head.
  logic                     cell_valid [CAPACITY];
  logic                     cell_gt    [CAPACITY];
  logic [PRIO_W-1:0]        cell_prio  [CAPACITY];
  logic [PAYLOAD_WIDTH-1:0] cell_payload [CAPACITY];

  logic                     in_fire;
  logic                     full;
  logic                     empty;
  cell_ctl_t                ctl;
  logic signed [63:0]       in_wide;
  logic [PAYLOAD_WIDTH-1:0] new_payload;
  logic signed [PAYLOAD_WIDTH-1:0] head_payload;
  logic signed [63:0]       head_wide;

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W+OCC_W-1:0]   count_ext;
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_word_r, out_word_nxt;

  // The output register separates the two sides; a new word is taken whenever
  // the held result is absent or leaving in this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign empty = !cell_valid[0];
  assign full  = cell_valid[CAPACITY-1];

  // Payloads are sign-extended from the input field and kept in the stored width.
  assign in_wide     = 64'(in_word.payload);
  assign new_payload = in_wide[PAYLOAD_WIDTH-1:0];

  // The command is broadcast to every cell. A rejected operation holds the row.
  always_comb begin
    ctl.new_prio = in_word.priority_req;
    ctl.cmd      = CMD_HOLD;
    if (in_fire) begin
      if (in_word.opcode == OP_INSERT) begin
        if (!full) begin
          ctl.cmd = CMD_INSERT;
        end
      end else if (!empty) begin
        ctl.cmd = CMD_POP;
      end
    end
  end

  // Each cell sees its left neighbor for inserts and its right neighbor for pops.
  // The head sees a virtual left neighbor that is valid and outranks everything,
  // so a new entry lands there when no stored entry beats it.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     l_valid, l_gt, r_valid;
    logic [PRIO_W-1:0]        l_prio, r_prio;
    logic [PAYLOAD_WIDTH-1:0] l_payload, r_payload;

    if (i == 0) begin : g_head
      assign l_valid   = 1'b1;
      assign l_gt      = 1'b1;
      assign l_prio    = '0;
      assign l_payload = '0;
    end else begin : g_mid
      assign l_valid   = cell_valid[i-1];
      assign l_gt      = cell_gt[i-1];
      assign l_prio    = cell_prio[i-1];
      assign l_payload = cell_payload[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_valid   = 1'b0;
      assign r_prio    = '0;
      assign r_payload = '0;
    end else begin : g_body
      assign r_valid   = cell_valid[i+1];
      assign r_prio    = cell_prio[i+1];
      assign r_payload = cell_payload[i+1];
    end

    spq_cell #(
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .new_payload  (new_payload),
      .left_valid   (l_valid),
      .left_gt      (l_gt),
      .left_prio    (l_prio),
      .left_payload (l_payload),
      .right_valid  (r_valid),
      .right_prio   (r_prio),
      .right_payload(r_payload),
      .valid        (cell_valid[i]),
      .gt           (cell_gt[i]),
      .prio         (cell_prio[i]),
      .payload      (cell_payload[i])
    );
  end

  // The popped payload is sign-extended from the stored width, then cut to the field.
  assign head_payload = cell_payload[0];
  assign head_wide    = 64'(head_payload);

  always_comb begin
    count_nxt = count_r;
    case (ctl.cmd)
      CMD_INSERT: count_nxt = count_r + CNT_W'(1);
      CMD_POP:    count_nxt = count_r - CNT_W'(1);
      default:    ;
    endcase
  end

  // The occupancy field is five bits wide and wraps for large capacities.
  assign count_ext = (CNT_W + OCC_W)'(count_nxt);

  always_comb begin
    out_word_nxt              = '0;
    out_word_nxt.status       = ST_OK;
    out_word_nxt.occupancy    = count_ext[OCC_W-1:0];
    if (in_word.opcode == OP_INSERT) begin
      if (full) begin
        out_word_nxt.status = ST_FULL;
      end
    end else if (empty) begin
      out_word_nxt.status = ST_EMPTY;
    end else begin
      out_word_nxt.out_priority = cell_prio[0];
      out_word_nxt.out_payload  = head_wide[DATA_W-1:0];
    end
  end

  assign out_valid_nxt = in_fire || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Neighboring valid cells must be in descending priority order.
  logic [CAPACITY-2:0] ordered;
  for (genvar k = 0; k < CAPACITY - 1; k++) begin : g_chk
    assign ordered[k] = !cell_valid[k+1] ||
                        (cell_valid[k] && (cell_prio[k] >= cell_prio[k+1]));
  end

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    &ordered)
    else $error("queue cells out of priority order");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    empty == (count_r == '0))
    else $error("head valid bit disagrees with entry count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    full == (count_r == CNT_W'(CAPACITY)))
    else $error("tail valid bit disagrees with entry count");

  a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cmd == CMD_POP) |=>
      (out_word_r.out_priority == $past(cell_prio[0])) &&
      (out_word_r.status == ST_OK))
    else $error("pop did not return the head entry");

endmodule

@@ dv/sorted_priority_queue_test.sv @@
`timescale 1ns / 1ps

module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int RANDOM_WORDS = 1025;
  localparam int BLOCK_WORDS  = 50;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 4;
  localparam int DIRECTED_N   = 25;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  sorted_priority_queue #(
    .CAPACITY      (QUEUE_DEPTH),
    .PAYLOAD_WIDTH (32)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // Free-running clock with a 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // A cycle counter guards against a hung handshake on either side.
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Mirror of the queue contents. Slot 0 is the head. The entries are kept in
  // descending priority order, and a new entry goes in front of every entry
  // with the same priority, so ties leave last in, first out.
  logic [PRIO_W-1:0]        mirror_prio [QUEUE_DEPTH];
  logic signed [DATA_W-1:0] mirror_data [QUEUE_DEPTH];
  int unsigned              mirror_count = 0;

  // Replies the queue owes us, oldest first.
  out_word_t awaited_replies [$];
  int unsigned mismatch_count = 0;

  // Applies one word to the mirror and returns the reply that it must produce.
  task automatic mirror_queue_op(input in_word_t w, output out_word_t reply);
    int unsigned slot;
    reply.status       = ST_OK;
    reply.out_priority = '0;
    reply.out_payload  = '0;
    if (op_t'(w.opcode) == OP_INSERT) begin
      if (mirror_count >= QUEUE_DEPTH) begin
        reply.status = ST_FULL;
      end else begin
        // Walk past the entries that strictly outrank the new one.
        slot = 0;
        while (slot < mirror_count && mirror_prio[slot] > w.priority_req) slot++;
        for (int i = mirror_count; i > slot; i--) begin
          mirror_prio[i] = mirror_prio[i-1];
          mirror_data[i] = mirror_data[i-1];
        end
        mirror_prio[slot] = w.priority_req;
        mirror_data[slot] = w.payload;
        mirror_count++;
      end
    end else begin
      if (mirror_count == 0) begin
        reply.status = ST_EMPTY;
      end else begin
        reply.out_priority = mirror_prio[0];
        reply.out_payload  = mirror_data[0];
        for (int i = 0; i + 1 < mirror_count; i++) begin
          mirror_prio[i] = mirror_prio[i+1];
          mirror_data[i] = mirror_data[i+1];
        end
        mirror_count--;
      end
    end
    reply.occupancy = mirror_count[OCC_W-1:0];
  endtask

  // Holds the word on the input until it is taken. The valid line is left high
  // so that a following word can go out on the very next edge; the caller
  // lowers it only when a gap is wanted. A pinned reply, where given, replaces
  // the mirror's answer as the expectation, but the mirror still advances.
  task automatic offer_word(input in_word_t w, input bit pinned, input out_word_t pin_reply);
    out_word_t reply;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror_queue_op(w, reply);
    awaited_replies.push_back(pinned ? pin_reply : reply);
  endtask

  // Mostly back to back, often a short pause, once in a while a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic input_pause(input int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // The random words come in blocks. Each block leans toward filling, draining
  // or holding the queue level, and draws priorities from one of several pools
  // so that ties, the two extremes and the full range all get exercised.
  function automatic in_word_t random_word(input int unsigned insert_pct,
                                           input int unsigned prio_pool);
    in_word_t w;
    w.opcode = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
    case (prio_pool)
      0: w.priority_req = PRIO_W'($urandom_range(0, 255));
      1: w.priority_req = PRIO_W'($urandom_range(0, 3));
      2: w.priority_req = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: w.priority_req = PRIO_W'(100 + $urandom_range(0, 7));
    endcase
    w.payload = $urandom();
    return w;
  endfunction

  // Directed words. Rows marked pinned carry a reply that can be read straight
  // off the queue behavior: an empty pop, a plain insert and a full insert all
  // return zero priority and payload together with a known count.
  typedef struct {
    op_t               op;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
    bit                pinned;
    status_t           status;
    logic [OCC_W-1:0]  occ;
  } directed_row_t;

  directed_row_t directed_rows [DIRECTED_N] = '{
    // Pop right after reset finds nothing.
    '{OP_POP,    8'd0,   32'h0000_0000, 1'b1, ST_EMPTY, 5'd0},
    // Lowest priority with the most negative payload, then the opposite corner.
    '{OP_INSERT, 8'd0,   32'h8000_0000, 1'b1, ST_OK,    5'd1},
    '{OP_INSERT, 8'd255, 32'h7FFF_FFFF, 1'b1, ST_OK,    5'd2},
    // A tie at the top: this later entry must come out first.
    '{OP_INSERT, 8'd255, 32'h0000_1234, 1'b1, ST_OK,    5'd3},
    '{OP_POP,    8'd0,   32'h0000_0000, 1'b0, ST_OK,    5'd0},
    '{OP_POP,    8'd0,   32'h0000_0000, 1'b0, ST_OK,    5'd0},
    '{OP_POP,    8'd0,   32'h0000_0000, 1'b0, ST_OK,    5'd0},
    '{OP_POP,    8'hFF,  32'hFFFF_FFFF, 1'b1, ST_EMPTY, 5'd0},
    // Fill every slot with a mix of ties and spread priorities.
    '{OP_INSERT, 8'd7,   32'h0000_0001, 1'b0, ST_OK,    5'd0},
    '{OP_INSERT, 8'd7,   32'hFFFF_FFFF, 1'b0, ST_OK,    5'd0},
    '{OP_INSERT, 8'd200, 32'h8000_0000, 1'b0, ST_OK,    5'd0},
    '{OP_INSERT, 8'd0,   32'h7FFF_FFFF, 1'b0, ST_OK,    5'd0},
    '{OP_INSERT, 8'd255, 32'h5555_5555, 1'b0, ST_OK,    5'd0},
    '{OP_INSERT, 8'd7,   32'hAAAA_AAAA, 1'b0, ST_OK,    5'd0},
    '{OP_INSERT, 8'd33,  32'h0F0F_0F0F, 1'b0, ST_OK,    5'd0},
    '{OP_INSERT, 8'd128, 32'hF0F0_F0F0, 1'b0, ST_OK,    5'd0},
    '{OP_INSERT, 8'd1,   32'h0000_0000, 1'b0, ST_OK,    5'd0},
    '{OP_INSERT, 8'd254, 32'h1234_5678, 1'b0, ST_OK,    5'd0},
    '{OP_INSERT, 8'd7,   32'h8765_4321, 1'b0, ST_OK,    5'd0},
    '{OP_INSERT, 8'd64,  32'h0000_FFFF, 1'b0, ST_OK,    5'd0},
    '{OP_INSERT, 8'd64,  32'hFFFF_0000, 1'b0, ST_OK,    5'd0},
    '{OP_INSERT, 8'd200, 32'h00FF_00FF, 1'b0, ST_OK,    5'd0},
    '{OP_INSERT, 8'd90,  32'hFF00_FF00, 1'b0, ST_OK,    5'd0},
    '{OP_INSERT, 8'd255, 32'h3C3C_3C3C, 1'b0, ST_OK,    5'd0},
    // The queue is full now, so this entry is turned away.
    '{OP_INSERT, 8'd150, 32'hDEAD_BEEF, 1'b1, ST_FULL,  5'd16}
  };

  // Main stimulus: reset, the directed rows, then random blocks, then drain.
  initial begin
    in_word_t    w;
    out_word_t   pin_reply;
    int unsigned sent;
    int unsigned insert_pct;
    int unsigned prio_pool;
    bit          no_gaps;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      w.opcode       = directed_rows[i].op;
      w.priority_req = directed_rows[i].prio;
      w.payload      = directed_rows[i].data;
      pin_reply.status       = directed_rows[i].status;
      pin_reply.out_priority = '0;
      pin_reply.out_payload  = '0;
      pin_reply.occupancy    = directed_rows[i].occ;
      offer_word(w, directed_rows[i].pinned, pin_reply);
      input_pause(pick_gap());
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 2))
        0: insert_pct = 85;
        1: insert_pct = 15;
        default: insert_pct = 50;
      endcase
      prio_pool = $urandom_range(0, 3);
      no_gaps   = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < BLOCK_WORDS && sent < RANDOM_WORDS; k++) begin
        offer_word(random_word(insert_pct, prio_pool), 1'b0, pin_reply);
        sent++;
        if (!no_gaps) input_pause(pick_gap());
      end
    end
    in_valid <= 1'b0;

    // Let every owed reply arrive, then watch a little longer for strays.
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // The result side takes words in stretches of varying length and then
  // stalls for a random gap, so stalls land on every phase of the traffic.
  initial begin
    int unsigned open_len;
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      open_len = $urandom_range(1, 40);
      out_ready <= 1'b1;
      repeat (open_len) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Every reply taken off the output is checked against the oldest one owed.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        $error("Reply arrived with nothing outstanding: status %0d", out_word.status);
        mismatch_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_word.status);
          mismatch_count++;
        end
        if (out_word.out_priority !== want.out_priority) begin
          $error("out_priority: expected %0d, actual %0d",
                 want.out_priority, out_word.out_priority);
          mismatch_count++;
        end
        if (out_word.out_payload !== want.out_payload) begin
          $error("out_payload: expected %0d, actual %0d",
                 want.out_payload, out_word.out_payload);
          mismatch_count++;
        end
        if (out_word.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, actual %0d",
                 want.occupancy, out_word.occupancy);
          mismatch_count++;
        end
      end
    end
  end

endmodule
